[rtl/core/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the FIFO replacement cache.
// ----------------------------------------------------------------------------
package frc_pkg;

   localparam int DEFAULT_CAPACITY = 8;
   localparam int VALUE_W          = 32;
   localparam int OCC_W            = 4;
   localparam int TOTAL_W          = 32;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_HIT       = 2'd0;
   localparam status_type STATUS_MISS      = 2'd1;
   localparam status_type STATUS_REMOVED   = 2'd2;
   localparam status_type STATUS_UNDERFLOW = 2'd3;

endpackage

[rtl/core/frc_if.sv]
// ----------------------------------------------------------------------------
// frc_if
// Request and response channels of the FIFO replacement cache.
// ----------------------------------------------------------------------------
interface frc_req_if
   import frc_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [VALUE_W-1:0] ref_value;

   modport source (output valid, output action, output ref_value, input ready);
   modport sink   (input valid, input action, input ref_value, output ready);
endinterface

interface frc_rsp_if
   import frc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic               evicted;
   logic [OCC_W-1:0]   occupancy;
   logic [TOTAL_W-1:0] hit_total;
   logic [TOTAL_W-1:0] miss_total;

   modport source (output valid, output status, output evicted, output occupancy,
                   output hit_total, output miss_total, input ready);
   modport sink   (input valid, input status, input evicted, input occupancy,
                   input hit_total, input miss_total, output ready);
endinterface

[rtl/core/fifo_replacement_cache.sv]
// A reference is compared in the scan state, one resident entry per cycle by the
// single comparator over the entry memory read port (every resident entry on a
// miss, up to the match on a hit); a reference on an empty store and a remove skip
// the scan. The finishing state then waits for a free output register, and a new
// word is accepted only once the block is back in idle.
// Reset clears the head pointer, occupancy, counters and control; the entry
// memory itself is not cleared, since only entries written by a miss are read.
// ----------------------------------------------------------------------------
// fifo_replacement_cache
// FIFO page replacement over a ring of entries held in a synchronous memory.
// ----------------------------------------------------------------------------
module fifo_replacement_cache
   import frc_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   frc_req_if.sink    req,
   frc_rsp_if.source  rsp
);

   // Index width addresses one slot; the count must also hold CAPACITY itself.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // The offset never exceeds CAPACITY, so one compare and subtract wraps it.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [IDX_W-1:0]   scan_off_ff, scan_off_in;
   logic               action_ff, action_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               hit_ff, hit_in;

   // The entry store, read through a registered read port.
   logic [VALUE_W-1:0] entry_store_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_slot;
   logic [IDX_W-1:0]   wr_slot;
   logic               wr_en;

   // Output register, so a finished word may wait while the next one is taken.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic [TOTAL_W-1:0] rsp_hit_ff, rsp_hit_in;
   logic [TOTAL_W-1:0] rsp_miss_ff, rsp_miss_in;

   logic               req_fire;
   logic               out_free;
   logic               full;
   logic               last_entry;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign last_entry = ((CNT_W'(scan_off_ff) + CNT_W'(1)) == count_ff);

   // On a miss into a full ring the oldest slot is reused; otherwise the value
   // goes into the first free slot behind the youngest entry.
   assign wr_slot = full ? head_ff : slot_of(head_ff, count_ff[IDX_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      scan_off_in    = scan_off_ff;
      action_in      = action_ff;
      value_in       = value_ff;
      hit_in         = hit_ff;
      rd_slot        = slot_of(head_ff, scan_off_ff + IDX_W'(1));
      wr_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_miss_in    = rsp_miss_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_slot = head_ff;
            if (req_fire) begin
               action_in   = req.action;
               value_in    = unsigned'(req.ref_value);
               hit_in      = 1'b0;
               scan_off_in = '0;
               // Removes and lookups in an empty store need no search.
               if (!req.action && (count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            // The read data belongs to the entry at scan_off_ff.
            if (rd_data_ff == value_ff) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end else if (last_entry) begin
               state_in = ST_FIN;
            end else begin
               scan_off_in = scan_off_ff + IDX_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_evicted_in = 1'b0;
               if (action_ff) begin
                  if (count_ff == '0) begin
                     rsp_status_in = STATUS_UNDERFLOW;
                  end else begin
                     rsp_status_in = STATUS_REMOVED;
                     head_in       = slot_of(head_ff, IDX_W'(1));
                     count_in      = count_ff - CNT_W'(1);
                  end
               end else if (hit_ff) begin
                  rsp_status_in = STATUS_HIT;
                  if (hit_cnt_ff != '1) begin
                     hit_cnt_in = hit_cnt_ff + TOTAL_W'(1);
                  end
               end else begin
                  rsp_status_in = STATUS_MISS;
                  wr_en         = 1'b1;
                  if (miss_cnt_ff != '1) begin
                     miss_cnt_in = miss_cnt_ff + TOTAL_W'(1);
                  end
                  if (full) begin
                     rsp_evicted_in = 1'b1;
                     head_in        = slot_of(head_ff, IDX_W'(1));
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               rsp_occ_in  = OCC_W'(count_in);
               rsp_hit_in  = hit_cnt_in;
               rsp_miss_in = miss_cnt_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Writes land in the finishing cycle; the next search reads no earlier than
   // the following cycle, so a read never overlaps a pending write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_slot] <= value_ff;
      end
      rd_data_ff <= entry_store_ff[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_off_ff    <= scan_off_in;
      action_ff      <= action_in;
      value_ff       <= value_in;
      hit_ff         <= hit_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_miss_ff    <= rsp_miss_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.evicted    = rsp_evicted_ff;
   assign rsp.occupancy  = rsp_occ_ff;
   assign rsp.hit_total  = rsp_hit_ff;
   assign rsp.miss_total = rsp_miss_ff;

endmodule
